/* hdl/rau_pkg.sv */
`default_nettype none

package rau_pkg;

  // Default operand width and fixed field widths.
  localparam int unsigned DEF_OPERAND_WIDTH = 16;
  localparam int unsigned CMD_W             = 3;
  localparam int unsigned ORDER_W           = 2;

  // Operation codes.
  localparam logic [CMD_W-1:0] OP_ADD = CMD_W'(0);
  localparam logic [CMD_W-1:0] OP_SUB = CMD_W'(1);
  localparam logic [CMD_W-1:0] OP_MUL = CMD_W'(2);
  localparam logic [CMD_W-1:0] OP_DIV = CMD_W'(3);
  localparam logic [CMD_W-1:0] OP_CMP = CMD_W'(4);

  // Compare result codes.
  localparam logic [ORDER_W-1:0] ORD_LESS    = ORDER_W'(0);
  localparam logic [ORDER_W-1:0] ORD_EQUAL   = ORDER_W'(1);
  localparam logic [ORDER_W-1:0] ORD_GREATER = ORDER_W'(2);

endpackage

`default_nettype wire

/* hdl/rau_if.sv */
`default_nettype none

// Request channel: opcode and two signed fractions.
interface rau_req_if
  import rau_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = DEF_OPERAND_WIDTH
);
  logic                            valid;
  logic                            ready;
  logic [CMD_W-1:0]                cmd;
  logic signed [OPERAND_WIDTH-1:0] left_num;
  logic signed [OPERAND_WIDTH-1:0] left_den;
  logic signed [OPERAND_WIDTH-1:0] right_num;
  logic signed [OPERAND_WIDTH-1:0] right_den;

  modport source (
    output valid, cmd, left_num, left_den, right_num, right_den,
    input  ready
  );
  modport sink (
    input  valid, cmd, left_num, left_den, right_num, right_den,
    output ready
  );
endinterface

// Result channel: reduced fraction, compare order and zero denominator flag.
interface rau_res_if
  import rau_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = DEF_OPERAND_WIDTH
);
  logic                              valid;
  logic                              ready;
  logic signed [2*OPERAND_WIDTH:0]   res_num;
  logic        [2*OPERAND_WIDTH-2:0] res_den;
  logic        [ORDER_W-1:0]         order;
  logic                              zero_den;

  modport source (
    output valid, res_num, res_den, order, zero_den,
    input  ready
  );
  modport sink (
    input  valid, res_num, res_den, order, zero_den,
    output ready
  );
endinterface

`default_nettype wire

/* hdl/rau_reduce.sv */
`default_nettype none

// Reduces a pair of nonzero magnitudes by their greatest common divisor.
// Binary gcd strips common factors of two from all four values, then runs
// odd-odd subtract steps; the odd gcd then divides both values, one
// restoring division step per cycle. One subtractor serves both phases.
module rau_reduce
  import rau_pkg::*;
#(
  parameter int unsigned MW = 2 * DEF_OPERAND_WIDTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [MW-1:0] n_in,
  input  wire logic [MW-1:0] d_in,
  output logic               done,
  output logic [MW-1:0]      q_num,
  output logic [MW-1:0]      q_den
);

  localparam int unsigned   CW   = $clog2(MW);
  localparam logic [CW-1:0] LAST = CW'(MW - 1);

  typedef enum logic [2:0] {
    R_IDLE,
    R_TWOS,
    R_ODD,
    R_DIVN,
    R_DIVD
  } rstate_t;

  rstate_t       state;
  logic [MW-1:0] u;
  logic [MW-1:0] v;
  logic [MW-1:0] n0;
  logic [MW-1:0] d0;
  logic [MW-1:0] dq;
  logic [MW-1:0] rem;
  logic [MW-1:0] qn;
  logic [CW-1:0] cnt;

  logic          u_gt_v;
  logic [MW-1:0] shifted;
  logic [MW-1:0] sub_a;
  logic [MW-1:0] sub_b;
  logic [MW:0]   diff;
  logic          ge;
  logic [MW-1:0] rem_next;
  logic [MW-1:0] dq_next;

  // Shared subtractor: larger minus smaller in the gcd, trial subtract in division.
  always_comb begin
    u_gt_v  = (u > v);
    shifted = {rem[MW-2:0], dq[MW-1]};
    if (state == R_ODD) begin
      sub_a = u_gt_v ? u : v;
      sub_b = u_gt_v ? v : u;
    end else begin
      sub_a = shifted;
      sub_b = u;
    end
    diff     = {1'b0, sub_a} - {1'b0, sub_b};
    ge       = ~diff[MW];
    rem_next = ge ? diff[MW-1:0] : shifted;
    dq_next  = {dq[MW-2:0], ge};
  end

  assign q_num = qn;
  assign q_den = dq;

  // Sequencer for the gcd and the two exact divisions.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        R_IDLE: begin
          if (start) begin
            u     <= n_in;
            v     <= d_in;
            n0    <= n_in;
            d0    <= d_in;
            state <= R_TWOS;
          end
        end
        R_TWOS: begin
          if (!u[0] && !v[0]) begin
            u  <= u >> 1;
            v  <= v >> 1;
            n0 <= n0 >> 1;
            d0 <= d0 >> 1;
          end else begin
            state <= R_ODD;
          end
        end
        R_ODD: begin
          if (!u[0]) begin
            u <= u >> 1;
          end else if (!v[0]) begin
            v <= v >> 1;
          end else if (u == v) begin
            dq    <= n0;
            rem   <= '0;
            cnt   <= '0;
            state <= R_DIVN;
          end else if (u_gt_v) begin
            u <= {1'b0, diff[MW-1:1]};
          end else begin
            v <= {1'b0, diff[MW-1:1]};
          end
        end
        R_DIVN: begin
          if (cnt == LAST) begin
            qn    <= dq_next;
            dq    <= d0;
            rem   <= '0;
            cnt   <= '0;
            state <= R_DIVD;
          end else begin
            dq  <= dq_next;
            rem <= rem_next;
            cnt <= cnt + CW'(1);
          end
        end
        R_DIVD: begin
          dq  <= dq_next;
          rem <= rem_next;
          cnt <= cnt + CW'(1);
          if (cnt == LAST) begin
            done  <= 1'b1;
            state <= R_IDLE;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/rational_arithmetic_unit_core.sv */
`default_nettype none

// Channel  Dir  Payload                                      Accepted when
// req      in   cmd, left_num, left_den, right_num, right_den valid && ready
// res      out  res_num, res_den, order, zero_den             valid && ready
//
// Compare and unused opcodes pass from request to result through three multiplier
// passes and the decision states S_PREP and S_DONE. A zero denominator or numerator
// also passes S_SIGN; otherwise S_SIGN starts the reducer, whose gcd and two exact
// divisions finish before the result is loaded.
// Reset is synchronous and returns both sequencers to idle with no result held.
// A finished result waits in the output register; a new request is taken meanwhile.
module rational_arithmetic_unit_core
  import rau_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = DEF_OPERAND_WIDTH
) (
  input  wire logic  clk,
  input  wire logic  rst,
  rau_req_if.sink    req,
  rau_res_if.source  res
);

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned NW = 2 * W + 1;
  localparam int unsigned DW = 2 * W - 1;
  localparam int unsigned MW = 2 * W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_PREP,
    S_SIGN,
    S_REDUCE,
    S_DONE
  } state_t;

  state_t              state;
  logic [1:0]          step;
  logic [CMD_W-1:0]    op;
  logic signed [W:0]   opa;
  logic signed [W:0]   opb;
  logic signed [W:0]   opc;
  logic signed [W:0]   opd;
  logic signed [NW-1:0] p0;
  logic signed [NW-1:0] p1;
  logic signed [NW-1:0] p2;
  logic signed [NW-1:0] num;
  logic                neg;
  logic [MW-1:0]       nmag;
  logic [MW-1:0]       dmag;
  logic                red_start;
  logic                red_done;
  logic [MW-1:0]       red_qn;
  logic [MW-1:0]       red_qd;

  logic signed [NW-1:0] rn;
  logic [DW-1:0]        rd;
  logic [ORDER_W-1:0]   ord;
  logic                 zf;

  logic                 out_valid;
  logic signed [NW-1:0] out_num;
  logic [DW-1:0]        out_den;
  logic [ORDER_W-1:0]   out_ord;
  logic                 out_zf;

  logic signed [W:0]    a_ext;
  logic signed [W:0]    b_ext;
  logic signed [W:0]    c_ext;
  logic signed [W:0]    d_ext;
  logic signed [W:0]    mul_x;
  logic signed [W:0]    mul_y;
  logic signed [2*W+1:0] prod;
  logic signed [NW-1:0] num_sum;
  logic signed [NW-1:0] num_neg;
  logic signed [NW-1:0] den_neg;
  logic [NW-1:0]        q_ext;

  // Sign-extended request operands.
  assign a_ext = {req.left_num[W-1], req.left_num};
  assign b_ext = {req.left_den[W-1], req.left_den};
  assign c_ext = {req.right_num[W-1], req.right_num};
  assign d_ext = {req.right_den[W-1], req.right_den};

  // Operand selection for the shared multiplier, one product per step.
  always_comb begin
    unique case (step)
      2'd0: begin
        mul_x = opa;
        mul_y = (op == OP_MUL) ? opc : opd;
      end
      2'd1: begin
        mul_x = opb;
        mul_y = opc;
      end
      default: begin
        mul_x = opb;
        mul_y = (op == OP_DIV) ? opc : opd;
      end
    endcase
  end

  assign prod = mul_x * mul_y;

  // Raw numerator from the registered products.
  always_comb begin
    case (op)
      OP_ADD:  num_sum = p0 + p1;
      OP_SUB:  num_sum = p0 - p1;
      default: num_sum = p0;
    endcase
  end

  assign num_neg = -num;
  assign den_neg = -p2;
  assign q_ext   = {1'b0, red_qn};

  rau_reduce #(
    .MW (MW)
  ) u_reduce (
    .clk   (clk),
    .rst   (rst),
    .start (red_start),
    .n_in  (nmag),
    .d_in  (dmag),
    .done  (red_done),
    .q_num (red_qn),
    .q_den (red_qd)
  );

  assign req.ready    = (state == S_IDLE);
  assign res.valid    = out_valid;
  assign res.res_num  = out_num;
  assign res.res_den  = out_den;
  assign res.order    = out_ord;
  assign res.zero_den = out_zf;

  // Main sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      red_start <= 1'b0;
    end else begin
      red_start <= 1'b0;
      // A taken result leaves unless a new one is loaded in its place below.
      if (out_valid && res.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op   <= req.cmd;
            step <= 2'd0;
            // Compare brings each operand to a nonnegative denominator.
            if (req.cmd == OP_CMP && req.left_den[W-1]) begin
              opa <= -a_ext;
              opb <= -b_ext;
            end else begin
              opa <= a_ext;
              opb <= b_ext;
            end
            if (req.cmd == OP_CMP && req.right_den[W-1]) begin
              opc <= -c_ext;
              opd <= -d_ext;
            end else begin
              opc <= c_ext;
              opd <= d_ext;
            end
            state <= S_MUL;
          end
        end
        S_MUL: begin
          unique case (step)
            2'd0:    p0 <= prod[NW-1:0];
            2'd1:    p1 <= prod[NW-1:0];
            default: p2 <= prod[NW-1:0];
          endcase
          if (step == 2'd2) begin
            state <= S_PREP;
          end else begin
            step <= step + 2'd1;
          end
        end
        S_PREP: begin
          num <= num_sum;
          rn  <= '0;
          rd  <= '0;
          zf  <= 1'b0;
          if (op == OP_CMP) begin
            if (p0 < p1) begin
              ord <= ORD_LESS;
            end else if (p0 == p1) begin
              ord <= ORD_EQUAL;
            end else begin
              ord <= ORD_GREATER;
            end
            state <= S_DONE;
          end else begin
            ord <= ORD_LESS;
            if (op > OP_DIV) begin
              state <= S_DONE;
            end else begin
              state <= S_SIGN;
            end
          end
        end
        S_SIGN: begin
          // Special cases first, then magnitudes for the reduction.
          if (p2 == '0) begin
            zf    <= 1'b1;
            state <= S_DONE;
          end else if (num == '0) begin
            rd    <= DW'(1);
            state <= S_DONE;
          end else begin
            neg       <= num[NW-1] ^ p2[NW-1];
            nmag      <= num[NW-1] ? num_neg[MW-1:0] : num[MW-1:0];
            dmag      <= p2[NW-1] ? den_neg[MW-1:0] : p2[MW-1:0];
            red_start <= 1'b1;
            state     <= S_REDUCE;
          end
        end
        S_REDUCE: begin
          if (red_done) begin
            rn    <= neg ? NW'(0) - q_ext : q_ext;
            rd    <= red_qd[DW-1:0];
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || res.ready) begin
            out_num   <= rn;
            out_den   <= rd;
            out_ord   <= ord;
            out_zf    <= zf;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* sim/rational_arithmetic_unit_core_tb.sv */
`default_nettype none

module rational_arithmetic_unit_core_tb;
  import rau_pkg::*;

  localparam int unsigned W          = DEF_OPERAND_WIDTH;
  localparam int          RANDOM_OPS = 1600;
  localparam int          QUIET_OPS  = 200;
  localparam int          STALL_MAX  = 5000;
  localparam int          DRAIN_WAIT = 300;

  typedef logic signed [W-1:0] operand_t;
  typedef logic [CMD_W-1:0]    opcode_t;

  typedef struct {
    logic signed [2*W:0] num;
    logic [2*W-2:0]      den;
    logic [ORDER_W-1:0]  order;
    logic                zero_den;
  } fraction_t;

  // Holds the reduced fractions still owed by the block, oldest first.
  class rational_tracker;
    fraction_t awaited_fractions[$];
    int        errors;
    int        op_seen[2**CMD_W];
    int        checked;
    int        flagged;
    int        zero_over_one;

    // Exact result of one request, in lowest terms with a positive denominator.
    function fraction_t exact_reduced(opcode_t cmd, operand_t a, operand_t b,
                                      operand_t c, operand_t d);
      longint          lnum, lden, rnum, rden, num, den, x, y;
      longint unsigned mn, md, g, t;
      fraction_t       r;
      r = '{num: '0, den: '0, order: '0, zero_den: 1'b0};
      lnum = a;
      lden = b;
      rnum = c;
      rden = d;
      num  = 0;
      den  = 0;
      case (cmd)
        OP_ADD: begin
          num = lnum * rden + lden * rnum;
          den = lden * rden;
        end
        OP_SUB: begin
          num = lnum * rden - lden * rnum;
          den = lden * rden;
        end
        OP_MUL: begin
          num = lnum * rnum;
          den = lden * rden;
        end
        OP_DIV: begin
          num = lnum * rden;
          den = lden * rnum;
        end
        OP_CMP: begin
          // Negative denominators are flipped so that the true order results.
          if (lden < 0) begin
            lnum = -lnum;
            lden = -lden;
          end
          if (rden < 0) begin
            rnum = -rnum;
            rden = -rden;
          end
          x = lnum * rden;
          y = lden * rnum;
          r.order = (x < y) ? ORD_LESS : ((x == y) ? ORD_EQUAL : ORD_GREATER);
          return r;
        end
        default: return r;
      endcase

      if (den == 0) begin
        r.zero_den = 1'b1;
      end else if (num == 0) begin
        r.den = 1;
      end else begin
        mn = (num < 0) ? -num : num;
        md = (den < 0) ? -den : den;
        x  = 0;
        g  = mn;
        t  = md;
        while (t != 0) begin
          x = g % t;
          g = t;
          t = x;
        end
        r.num = ((num < 0) != (den < 0)) ? -longint'(mn / g) : longint'(mn / g);
        r.den = md / g;
      end
      return r;
    endfunction

    function void note_request(opcode_t cmd, operand_t a, operand_t b,
                               operand_t c, operand_t d);
      fraction_t f;
      f = exact_reduced(cmd, a, b, c, d);
      awaited_fractions.push_back(f);
      op_seen[cmd]++;
      if (f.zero_den) flagged++;
      if (cmd < OP_CMP && !f.zero_den && f.num == 0) zero_over_one++;
    endfunction

    function void check_result(fraction_t got);
      fraction_t want;
      if (awaited_fractions.size() == 0) begin
        $error("result with no request outstanding: %0d/%0d order %0d flag %0d",
               got.num, got.den, got.order, got.zero_den);
        errors++;
        return;
      end
      want = awaited_fractions.pop_front();
      checked++;
      if (got.num !== want.num) begin
        $error("res_num: expected %0d, got %0d", want.num, got.num);
        errors++;
      end
      if (got.den !== want.den) begin
        $error("res_den: expected %0d, got %0d", want.den, got.den);
        errors++;
      end
      if (got.order !== want.order) begin
        $error("order: expected %0d, got %0d", want.order, got.order);
        errors++;
      end
      if (got.zero_den !== want.zero_den) begin
        $error("zero_den: expected %0d, got %0d", want.zero_den, got.zero_den);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic quiet = 1'b0;
  int   stall_cycles = 0;

  rational_tracker tracker = new();

  rau_req_if #(.OPERAND_WIDTH(W)) req ();
  rau_res_if #(.OPERAND_WIDTH(W)) res ();

  rational_arithmetic_unit_core #(.OPERAND_WIDTH(W)) dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res)
  );

  initial forever #6 clk = ~clk;

  // Presents one request from the falling edge and holds it until it is taken.
  task automatic send_op(opcode_t cmd, operand_t a, operand_t b, operand_t c,
                         operand_t d);
    @(negedge clk);
    req.valid     <= 1'b1;
    req.cmd       <= cmd;
    req.left_num  <= a;
    req.left_den  <= b;
    req.right_num <= c;
    req.right_den <= d;
    do @(posedge clk); while (!req.ready);
  endtask

  // Many small values so that reductions and equal compares are common,
  // some extremes, and half of all values over the full range.
  function automatic operand_t pick_operand();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 5))
          0: return '0;
          1: return operand_t'(1);
          2: return operand_t'(-1);
          3: return {1'b0, {(W-1){1'b1}}};
          4: return {1'b1, {(W-1){1'b0}}};
          default: return {1'b1, {(W-2){1'b0}}, 1'b1};
        endcase
      end
      1, 2, 3, 4: return operand_t'(int'($urandom_range(0, 24)) - 12);
      default: return operand_t'($urandom);
    endcase
  endfunction

  // Result side: random stall bursts, switched off for the final stretch.
  initial begin
    res.ready = 1'b0;
    wait (!rst);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        @(negedge clk) res.ready <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk);
      end else begin
        @(negedge clk) res.ready <= 1'b1;
        repeat ($urandom_range(0, 20)) @(negedge clk);
      end
    end
  end

  // Monitor both channels; also counts cycles in which nothing moves.
  always @(posedge clk) begin
    fraction_t got;
    if (!rst) begin
      if (req.valid && req.ready) begin
        tracker.note_request(req.cmd, req.left_num, req.left_den,
                             req.right_num, req.right_den);
      end
      if (res.valid && res.ready) begin
        got.num      = res.res_num;
        got.den      = res.res_den;
        got.order    = res.order;
        got.zero_den = res.zero_den;
        tracker.check_result(got);
      end
      if ((req.valid && req.ready) || (res.valid && res.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_MAX) begin
        $display("timeout: no request or result moved for %0d cycles", STALL_MAX);
        $display("rational_arithmetic_unit_core_tb: done, errors");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    opcode_t  cmd;
    operand_t a, b, c, d;
    int       k;

    req.valid     = 1'b0;
    req.cmd       = OP_ADD;
    req.left_num  = '0;
    req.left_den  = '0;
    req.right_num = '0;
    req.right_den = '0;

    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed requests: extremes, every opcode and each special case.
    send_op(OP_ADD, 1, 2, 1, 3);
    send_op(OP_SUB, 1, 2, 1, 2);
    send_op(OP_MUL, -2, 4, 3, -6);
    send_op(OP_DIV, 1, 2, 0, 5);
    send_op(OP_ADD, 1, 0, 1, 3);
    send_op(OP_MUL, -32768, 1, -32768, 1);
    send_op(OP_ADD, -32768, -32768, -32768, -32768);
    send_op(OP_SUB, -32768, 1, 32767, -1);
    send_op(OP_DIV, 32767, -32768, -32768, 32767);
    send_op(OP_ADD, -32768, 32767, 32767, -32768);
    send_op(OP_MUL, 0, 7, 5, 3);
    send_op(OP_DIV, 3, 4, 3, 4);
    send_op(OP_SUB, -1, -1, 1, 1);
    send_op(OP_DIV, 0, 0, 0, 0);
    send_op(OP_CMP, 1, 2, 2, 4);
    send_op(OP_CMP, -1, 2, 1, -3);
    send_op(OP_CMP, 1, -2, -1, 2);
    send_op(OP_CMP, 1, 0, 3, 4);
    send_op(OP_CMP, 0, 0, 0, 0);
    send_op(OP_CMP, 32767, 1, -32768, 1);
    send_op(OP_CMP, -32768, -32768, 32767, -32768);
    for (int u = OP_CMP + 1; u < 2**CMD_W; u++) begin
      send_op(opcode_t'(u), -1, -1, -32768, 32767);
    end

    // Random requests; gaps stop for the last stretch.
    for (int i = 0; i < RANDOM_OPS; i++) begin
      if (i == RANDOM_OPS - QUIET_OPS) quiet = 1'b1;
      if (!quiet && $urandom_range(0, 2) == 0) begin
        @(negedge clk) req.valid <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk);
      end
      if ($urandom_range(0, 19) != 0) begin
        cmd = opcode_t'($urandom_range(OP_ADD, OP_CMP));
      end else begin
        cmd = opcode_t'($urandom_range(OP_CMP + 1, 2**CMD_W - 1));
      end
      a = pick_operand();
      b = pick_operand();
      c = pick_operand();
      d = pick_operand();
      // Scaled copies give equal fractions to compare and to cancel.
      if ($urandom_range(0, 4) == 0) begin
        k = int'($urandom_range(1, 5));
        if ($urandom_range(0, 1) == 1) k = -k;
        c = operand_t'(int'(a) * k);
        d = operand_t'(int'(b) * k);
      end
      send_op(cmd, a, b, c, d);
    end
    @(negedge clk) req.valid <= 1'b0;

    while (tracker.awaited_fractions.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Checked %0d results: %0d add, %0d subtract, %0d multiply, %0d divide, %0d compare.",
             tracker.checked, tracker.op_seen[OP_ADD], tracker.op_seen[OP_SUB],
             tracker.op_seen[OP_MUL], tracker.op_seen[OP_DIV], tracker.op_seen[OP_CMP]);
    $display("Unused opcodes %0d, zero denominators %0d, results reduced to 0/1 %0d.",
             tracker.op_seen[5] + tracker.op_seen[6] + tracker.op_seen[7],
             tracker.flagged, tracker.zero_over_one);
    if (tracker.errors == 0) begin
      $display("rational_arithmetic_unit_core_tb: done, clean");
    end else begin
      $display("rational_arithmetic_unit_core_tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* rational_arithmetic_unit_core.f */
hdl/rau_pkg.sv
hdl/rau_if.sv
hdl/rau_reduce.sv
hdl/rational_arithmetic_unit_core.sv
sim/rational_arithmetic_unit_core_tb.sv
